// File: rtl/sdf_pkg.sv
// Shared types and default sizes for the stream duplicate filter.
`default_nettype none

package sdf_pkg;

  // Default sizes handed to the top level parameters
  localparam int SEEN_DEPTH_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Control bits that travel with a transaction along the cell chain
  typedef struct packed {
    logic valid;  // slot holds a transaction
    logic last;   // end of list marker
    logic found;  // value matched a stored entry upstream
    logic done;   // found, or stored by an upstream cell
  } sdf_tag_t;

  // Result flags held in the output stage
  typedef struct packed {
    logic keep;
    logic overflow;
    logic last;
  } sdf_flags_t;

endpackage

`default_nettype wire

// File: rtl/sdf_in_if.sv
// Input channel of the duplicate filter: one list element per transaction.
`default_nettype none

interface sdf_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          end_of_list;

  modport source (output valid, output value, output end_of_list, input ready);
  modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

`default_nettype wire

// File: rtl/sdf_out_if.sv
// Output channel of the duplicate filter: one result per transaction.
`default_nettype none

interface sdf_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value_out;
  logic                          keep;
  logic                          overflow;
  logic                          end_out;

  modport source (output valid, output value_out, output keep, output overflow,
                  output end_out, input ready);
  modport sink   (input valid, input value_out, input keep, input overflow,
                  input end_out, output ready);
endinterface

`default_nettype wire

// File: rtl/sdf_cell.sv
// One cell of the filter chain: holds one seen value and checks passing transactions.
`default_nettype none

module sdf_cell
  import sdf_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire sdf_tag_t               tag_in,
  input  wire logic [VALUE_WIDTH-1:0] val_in,
  output sdf_tag_t                    tag_out,
  output logic      [VALUE_WIDTH-1:0] val_out
);

  logic                   occ;
  logic [VALUE_WIDTH-1:0] stored;
  logic                   match;
  logic                   take;

  // Compare against the held value; claim the cell if empty and not yet placed
  assign match = occ && (stored == val_in);
  assign take  = tag_in.valid && !tag_in.done && !occ;

  // Occupancy: set on claim, cleared once the end of list passes
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (adv && tag_in.valid) begin
      if (tag_in.last) begin
        occ <= 1'b0;
      end else if (take) begin
        occ <= 1'b1;
      end
    end
  end

  // Stored value, no reset needed
  always_ff @(posedge clk) begin
    if (adv && take) begin
      stored <= val_in;
    end
  end

  // Hand the transaction on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out.valid <= tag_in.valid;
      tag_out.last  <= tag_in.last;
      tag_out.found <= tag_in.found || match;
      tag_out.done  <= tag_in.done || match || take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_out <= val_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sdf_skid.sv
// Two-entry output stage that decouples the cell chain from the receiver.
`default_nettype none

module sdf_skid
  import sdf_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire logic [VALUE_WIDTH-1:0] push_value,
  input  wire sdf_flags_t             push_flags,
  output logic                        room,
  sdf_out_if.source                   dout
);

  logic [1:0]             count;
  logic [VALUE_WIDTH-1:0] front_value;
  logic [VALUE_WIDTH-1:0] tail_value;
  sdf_flags_t             head_flags;
  sdf_flags_t             tail_flags;
  logic                   pop;

  assign pop  = (count != 2'd0) && dout.ready;
  assign room = (count != 2'd2);

  assign dout.valid     = (count != 2'd0);
  assign dout.value_out = front_value;
  assign dout.keep      = head_flags.keep;
  assign dout.overflow  = head_flags.overflow;
  assign dout.end_out   = head_flags.last;

  // Fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (!push && pop) begin
      count <= count - 2'd1;
    end
  end

  // Data movement between head and tail
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        front_value <= push_value;
        head_flags  <= push_flags;
      end else begin
        tail_value <= push_value;
        tail_flags <= push_flags;
      end
    end else if (push && pop) begin
      if (count == 2'd1) begin
        front_value <= push_value;
        head_flags  <= push_flags;
      end else begin
        front_value <= tail_value;
        head_flags  <= tail_flags;
        tail_value  <= push_value;
        tail_flags  <= push_flags;
      end
    end else if (pop) begin
      front_value <= tail_value;
      head_flags  <= tail_flags;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stream_duplicate_filter.sv
// Top level of the stream duplicate filter: cell chain and output stage.
//
// Usage:
//   din carries one list element per transaction (value, end_of_list).
//   dout carries one result per element, in order: value_out, keep (first
//   occurrence in this list), overflow (new value that found every cell
//   taken), end_out (copy of end_of_list).
//   Each of the SEEN_DEPTH cells holds one seen value; a transaction walks
//   the chain one cell per cycle while the output stage has room, matching
//   or claiming the first free cell. The end of list marker empties each
//   cell as it passes, so the next list starts clean without a gap.
// Timing:
//   A transaction passes the register of every cell and then the output
//   stage before it shows on dout. Throughput is one transaction per cycle
//   while the output stage has room, as the chain steps once a cycle.
// Reset and stall:
//   rst (synchronous) empties every cell and the output stage; din.ready is
//   high in the cycle after reset. When dout is stalled the two-entry output
//   stage fills; once full the whole chain holds and din.ready drops. The
//   result on dout holds steady until taken.
`default_nettype none

module stream_duplicate_filter
  import sdf_pkg::*;
#(
  parameter int SEEN_DEPTH  = SEEN_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sdf_in_if.sink     din,
  sdf_out_if.source  dout
);

  sdf_tag_t               stage_tag [SEEN_DEPTH+1];
  logic [VALUE_WIDTH-1:0] stage_val [SEEN_DEPTH+1];
  logic                   adv;
  logic                   room;
  sdf_flags_t             tail_flags;

  // Chain steps whenever the output stage has room
  assign adv       = room;
  assign din.ready = room;

  // Chain entry
  assign stage_tag[0].valid = din.valid;
  assign stage_tag[0].last  = din.end_of_list;
  assign stage_tag[0].found = 1'b0;
  assign stage_tag[0].done  = 1'b0;
  assign stage_val[0]       = din.value;

  // Row of cells
  for (genvar k = 0; k < SEEN_DEPTH; k++) begin : g_cell
    sdf_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tag_in  (stage_tag[k]),
      .val_in  (stage_val[k]),
      .tag_out (stage_tag[k+1]),
      .val_out (stage_val[k+1])
    );
  end

  // Result flags at the end of the chain
  assign tail_flags.keep     = !stage_tag[SEEN_DEPTH].found;
  assign tail_flags.overflow = !stage_tag[SEEN_DEPTH].done;
  assign tail_flags.last     = stage_tag[SEEN_DEPTH].last;

  sdf_skid #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (adv && stage_tag[SEEN_DEPTH].valid),
    .push_value (stage_val[SEEN_DEPTH]),
    .push_flags (tail_flags),
    .room       (room),
    .dout       (dout)
  );

endmodule

`default_nettype wire

// File: rtl/sdf_check.sv
// Port checker for the stream duplicate filter, bound to the top level.
`default_nettype none

module sdf_check #(
  parameter int VALUE_WIDTH = 32
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   din_ready,
  input wire logic                   dout_valid,
  input wire logic                   dout_ready,
  input wire logic [VALUE_WIDTH-1:0] dout_value,
  input wire logic                   dout_keep,
  input wire logic                   dout_overflow
);

  // Result held while the receiver stalls
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_ready |=> dout_valid)
    else $error("result dropped under stall");

  a_hold_value : assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_ready |=> $stable(dout_value))
    else $error("result value changed under stall");

  // A duplicate never reports an unrecorded new value
  a_ovf_keep : assert property (@(posedge clk) disable iff (rst)
    dout_valid && dout_overflow |-> dout_keep)
    else $error("overflow on a dropped duplicate");

  // Reset leaves no result pending and the input open
  a_reset : assert property (@(posedge clk)
    rst |=> !dout_valid && din_ready)
    else $error("output stage not empty after reset");

endmodule

bind stream_duplicate_filter sdf_check #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_sdf_check (
  .clk           (clk),
  .rst           (rst),
  .din_ready     (din.ready),
  .dout_valid    (dout.valid),
  .dout_ready    (dout.ready),
  .dout_value    (dout.value_out),
  .dout_keep     (dout.keep),
  .dout_overflow (dout.overflow)
);

`default_nettype wire
